@@ rtl/atoc_pkg.sv @@
package atoc_pkg;

    localparam int NameCharW = 10;
    localparam logic [NameCharW-1:0] NameCharLimitReset = 10'd260;
    localparam logic [NameCharW-1:0] NameCharMax = 10'd1023;
    localparam int HeaderBytes = 16;
    localparam int QueueDepth = 4;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_OFFSET = 3'd1,
        PH_SIZE   = 3'd2,
        PH_NAME   = 3'd3,
        PH_DONE   = 3'd4,
        PH_HALT   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        K_NAME   = 2'd0,
        K_HEADER = 2'd1,
        K_ENTRY  = 2'd2,
        K_FINAL  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_ZERO_OFF  = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_TRUNCATED = 3'd5
    } t_status;

    localparam logic [31:0] SigBig2 = 32'h42494732;
    localparam logic [31:0] SigBig3 = 32'h42494733;
    localparam logic [31:0] SigBig4 = 32'h42494734;
    localparam logic [31:0] SigBig5 = 32'h42494735;
    localparam logic [31:0] SigC0fb = 32'h63306662;
    localparam logic [31:0] SigBigf = 32'h42494746;
    localparam logic [2:0] KindBigf = 3'd5;

    // One classified event from the front part.
    typedef struct packed {
        logic          emit;
        t_kind         kind;
        logic [7:0]    name_byte;
        logic [39:0]   entry_offset;
        logic [31:0]   entry_size;
        logic [9:0]    name_chars;
        logic [2:0]    archive_kind;
        logic [31:0]   file_length;
        logic [31:0]   entry_count;
        logic [31:0]   header_length;
        logic          fin;
        t_status       status;
    } t_event;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_byte;
        logic [39:0] entry_offset;
        logic [31:0] entry_size;
        logic [9:0]  name_chars;
        logic [2:0]  archive_kind;
        logic [31:0] file_length;
        logic [31:0] entry_count;
        logic [31:0] header_length;
        t_status     status;
    } t_result;

    function automatic logic [2:0] off_width(input logic [2:0] k);
        case (k)
            3'd0:    off_width = 3'd2;
            3'd1:    off_width = 3'd3;
            3'd2:    off_width = 3'd4;
            3'd3:    off_width = 3'd5;
            3'd4:    off_width = 3'd3;
            default: off_width = 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] size_width(input logic [2:0] k);
        case (k)
            3'd0:    size_width = 3'd2;
            3'd1:    size_width = 3'd3;
            3'd2:    size_width = 3'd4;
            3'd3:    size_width = 3'd4;
            3'd4:    size_width = 3'd3;
            default: size_width = 3'd0;
        endcase
    endfunction

endpackage

@@ rtl/atoc_front.sv @@
module atoc_front import atoc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [NameCharW-1:0] i_limit,
    output t_event               o_ev0,
    output t_event               o_ev1
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [2:0]  r_kcode, n_kcode;
    logic [31:0] r_alen, n_alen;
    logic [31:0] r_dent, n_dent;
    logic [31:0] r_dhl, n_dhl;
    logic [31:0] r_done, n_done;
    logic [31:0] r_seen, n_seen;
    logic [39:0] r_off, n_off;
    logic [31:0] r_size, n_size;
    logic [9:0]  r_cnt, n_cnt;
    t_status     r_err, n_err;
    logic [31:0] sig;
    logic        found;
    logic [2:0]  fk;
    logic [3:0]  idx1;
    logic [9:0]  cnt1;
    t_status     st;

    always_comb begin
        n_phase = r_phase; n_idx = r_idx; n_kcode = r_kcode; n_alen = r_alen;
        n_dent = r_dent; n_dhl = r_dhl; n_done = r_done; n_off = r_off;
        n_size = r_size; n_cnt = r_cnt; n_err = r_err;
        n_seen = (r_seen != 32'hFFFFFFFF) ? r_seen + 32'd1 : r_seen;
        o_ev0 = '0;
        o_ev1 = '0;
        sig = {r_off[23:0], i_byte};
        found = 1'b0;
        fk = 3'd0;
        idx1 = r_idx + 4'd1;
        cnt1 = r_cnt;
        st = ST_OK;
        case (sig)
            SigBig2: begin found = 1'b1; fk = 3'd0; end
            SigBig3: begin found = 1'b1; fk = 3'd1; end
            SigBig4: begin found = 1'b1; fk = 3'd2; end
            SigBig5: begin found = 1'b1; fk = 3'd3; end
            SigC0fb: begin found = 1'b1; fk = 3'd4; end
            SigBigf: begin found = 1'b1; fk = KindBigf; end
            default: begin found = 1'b0; fk = 3'd0; end
        endcase
        case (r_phase)
            PH_HEADER: begin
                n_idx = idx1;
                if (r_idx < 4'd4) n_off = {8'd0, sig};
                else if (r_idx < 4'd8) n_alen = {r_alen[23:0], i_byte};
                else if (r_idx < 4'd12) n_dent = {r_dent[23:0], i_byte};
                else n_dhl = {r_dhl[23:0], i_byte};
                if (r_idx == 4'd3) begin
                    if (found) n_kcode = fk;
                    else begin n_err = ST_BAD_SIG; n_phase = PH_HALT; end
                end
                if (r_idx == 4'(HeaderBytes - 1)) begin
                    o_ev0.emit = 1'b1;
                    o_ev0.kind = K_HEADER;
                    o_ev0.archive_kind = r_kcode;
                    o_ev0.file_length = r_alen;
                    o_ev0.entry_count = r_dent;
                    o_ev0.header_length = n_dhl;
                    n_idx = 4'd0;
                    if (r_dent == 32'd0) n_phase = PH_DONE;
                    else if (r_kcode == KindBigf) begin
                        n_err = ST_ZERO_OFF; n_phase = PH_HALT;
                    end else begin
                        n_phase = PH_OFFSET; n_off = '0; n_size = '0; n_cnt = '0;
                    end
                end
            end
            PH_OFFSET: begin
                n_off = {r_off[31:0], i_byte};
                n_idx = idx1;
                if ({1'b0, idx1} >= {2'b0, off_width(r_kcode)}) begin
                    if (n_off == 40'd0) begin n_err = ST_ZERO_OFF; n_phase = PH_HALT; end
                    else begin n_phase = PH_SIZE; n_idx = 4'd0; end
                end
            end
            PH_SIZE: begin
                n_size = {r_size[23:0], i_byte};
                n_idx = idx1;
                if ({1'b0, idx1} >= {2'b0, size_width(r_kcode)}) begin
                    n_phase = PH_NAME; n_idx = 4'd0; n_cnt = '0;
                end
            end
            PH_NAME: begin
                if (i_byte == 8'd0) begin
                    if (r_cnt == 10'd0) begin n_err = ST_EMPTY; n_phase = PH_HALT; end
                    else begin
                        o_ev0.emit = 1'b1;
                        o_ev0.kind = K_ENTRY;
                        o_ev0.entry_offset = r_off;
                        o_ev0.entry_size = r_size;
                        o_ev0.name_chars = r_cnt;
                        n_done = r_done + 32'd1;
                        if (n_done >= r_dent) n_phase = PH_DONE;
                        else begin
                            n_phase = PH_OFFSET; n_idx = 4'd0; n_off = '0;
                            n_size = '0; n_cnt = '0;
                        end
                    end
                end else begin
                    if (i_byte[7:6] != 2'b10 && r_cnt != NameCharMax) cnt1 = r_cnt + 10'd1;
                    n_cnt = cnt1;
                    if (cnt1 > i_limit) begin n_err = ST_TOO_LONG; n_phase = PH_HALT; end
                    else begin
                        o_ev0.emit = 1'b1;
                        o_ev0.kind = K_NAME;
                        o_ev0.name_byte = i_byte;
                        o_ev0.name_chars = cnt1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (i_last) begin
            st = n_err;
            if (st == ST_OK && (n_phase != PH_DONE || n_done < n_dent ||
                n_dhl < 32'(HeaderBytes) || n_seen < n_dhl))
                st = ST_TRUNCATED;
            o_ev1.emit = 1'b1;
            o_ev1.kind = K_FINAL;
            o_ev1.fin = 1'b1;
            o_ev1.status = st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_HEADER; r_idx <= '0; r_kcode <= '0; r_alen <= '0;
            r_dent <= '0; r_dhl <= '0; r_done <= '0; r_seen <= '0;
            r_off <= '0; r_size <= '0; r_cnt <= '0; r_err <= ST_OK;
        end else if (i_step) begin
            r_phase <= n_phase; r_idx <= n_idx; r_kcode <= n_kcode;
            r_alen <= n_alen; r_dent <= n_dent; r_dhl <= n_dhl;
            r_done <= n_done; r_seen <= n_seen; r_off <= n_off;
            r_size <= n_size; r_cnt <= n_cnt; r_err <= n_err;
        end
    end

endmodule

@@ rtl/atoc_queue.sv @@
module atoc_queue import atoc_pkg::*; #(
    parameter int Depth = QueueDepth
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push0,
    input  t_result i_d0,
    input  logic    i_push1,
    input  t_result i_d1,
    output logic    o_room2,
    output logic    o_valid,
    output t_result o_q,
    input  logic    i_pop
);

    localparam int AW = $clog2(Depth);

    t_result             r_mem [Depth];
    logic [AW-1:0]       r_wp, r_rp;
    logic [AW:0]         r_cnt;
    logic [AW-1:0]       wp1;
    logic [1:0]          npush;

    assign wp1 = r_wp + AW'(1);
    assign npush = {1'b0, i_push0} + {1'b0, i_push1};
    assign o_valid = r_cnt != '0;
    assign o_q = r_mem[r_rp];
    assign o_room2 = r_cnt <= (AW+1)'(Depth - 2);

    always_ff @(posedge i_clk) begin
        if (i_push0) r_mem[r_wp] <= i_d0;
        if (i_push1) r_mem[i_push0 ? wp1 : r_wp] <= i_d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= r_wp + AW'(npush);
            if (i_pop && o_valid) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(npush) - (AW+1)'(i_pop && o_valid);
        end
    end

endmodule

@@ rtl/atoc_back.sv @@
module atoc_back import atoc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_result      i_q,
    output logic         o_pop,
    output logic         o_tvalid,
    output logic [191:0] o_tdata,
    output logic [1:0]   o_tuser,
    output logic         o_tlast,
    input  logic         i_tready
);

    logic    r_valid;
    t_result r_q;

    assign o_pop = i_valid && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_tuser = r_q.kind;
    assign o_tlast = r_q.kind == K_FINAL;
    assign o_tdata = {r_q.status, r_q.header_length, r_q.entry_count,
                      r_q.file_length, r_q.archive_kind, r_q.name_chars,
                      r_q.entry_size, r_q.entry_offset, r_q.name_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (o_pop) r_valid <= 1'b1;
        else if (i_tready) r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_q <= i_q;
    end

endmodule

@@ rtl/archive_toc_stream_parser.sv @@
// Parses an archive header byte stream, one byte per cycle, into results on the
// master side: tuser gives the kind (name byte, header info, entry complete, final
// status) and tlast marks the final status that follows the byte marked tlast on the
// slave side. A byte is taken in the cycle it arrives when the four-entry result queue
// has room for two results; the output register drains the queue at one result a
// cycle, so the sustained rate is one byte per cycle while the sink keeps up.
module archive_toc_stream_parser import atoc_pkg::*; #(
    parameter int QDepth = QueueDepth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // data_byte
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // name_byte, entry_offset, entry_size, name_chars, archive_kind,
    // file_length, entry_count, header_length, status
    output logic [191:0]         m_axis_tdata,
    output logic [1:0]           m_axis_tuser,   // kind
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [NameCharW-1:0] i_cfg_wdata
);

    logic [NameCharW-1:0] r_limit;
    logic    step, room, qv, pop;
    t_event  ev0, ev1;
    t_result d0, d1, q;

    assign s_axis_tready = room;
    assign step = s_axis_tvalid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= NameCharLimitReset;
        else if (i_cfg_we) r_limit <= i_cfg_wdata;
    end

    atoc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_byte(s_axis_tdata),
        .i_last(s_axis_tlast), .i_limit(r_limit), .o_ev0(ev0), .o_ev1(ev1)
    );

    assign d0 = '{ev0.kind, ev0.name_byte, ev0.entry_offset, ev0.entry_size,
                  ev0.name_chars, ev0.archive_kind, ev0.file_length, ev0.entry_count,
                  ev0.header_length, ev0.status};
    assign d1 = '{ev1.kind, ev1.name_byte, ev1.entry_offset, ev1.entry_size,
                  ev1.name_chars, ev1.archive_kind, ev1.file_length, ev1.entry_count,
                  ev1.header_length, ev1.status};

    atoc_queue #(.Depth(QDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push0(step && ev0.emit), .i_d0(d0),
        .i_push1(step && ev1.emit && ev1.fin), .i_d1(d1),
        .o_room2(room), .o_valid(qv), .o_q(q), .i_pop(pop)
    );

    atoc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(qv), .i_q(q), .o_pop(pop),
        .o_tvalid(m_axis_tvalid), .o_tdata(m_axis_tdata), .o_tuser(m_axis_tuser),
        .o_tlast(m_axis_tlast), .i_tready(m_axis_tready)
    );

endmodule

@@ rtl/atoc_checker.sv @@
module atoc_checker import atoc_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == K_FINAL)))
        else $error("tlast disagrees with kind");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[191:189] <= 3'd5)
        else $error("bad status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(s_axis_tready))
        else $error("input ready unknown");

endmodule

bind archive_toc_stream_parser atoc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
